### hdl/rc4_pkg.sv
// shared types and constants of the rc4 stream cipher
// command and status structs between controller and datapath, op and register codes
// no dependencies
package rc4_pkg;

    localparam int PERM_SIZE = 256;
    localparam int KEY_BYTES = 32;
    localparam int KPOS_W    = $clog2(KEY_BYTES);
    localparam int LEN_W     = 6;
    localparam int WORD_W    = 64;
    localparam int KEY_WORDS = (KEY_BYTES * 8) / WORD_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_REKEY  = 2'd0,
        OP_DATA   = 2'd1,
        OP_MARKER = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH = 3'd0,
        REG_KEY_WORD_0 = 3'd1,
        REG_KEY_WORD_1 = 3'd2,
        REG_KEY_WORD_2 = 3'd3,
        REG_KEY_WORD_3 = 3'd4
    } cfg_reg_t;

    // read address source
    typedef enum logic [2:0] {
        RD_INC_I  = 3'd0,
        RD_I      = 3'd1,
        RD_J_DATA = 3'd2,
        RD_J_KEY  = 3'd3,
        RD_T      = 3'd4
    } rd_sel_t;

    // write address and data source
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_I_RD  = 2'd1,
        WR_J_SI  = 2'd2
    } wr_sel_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    perm_clr;
        logic    idx_clr;
        logic    i_inc;
        logic    j_load;
        logic    si_save;
        logic    sj_save;
        logic    t_save;
        logic    din_load;
        logic    key_clr;
        logic    key_adv;
        logic    out_data;
        logic    out_marker;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_n;
    } sts_t;

endpackage

### hdl/rc4_stream_cipher.sv
// rc4 stream cipher: a data byte's result is registered after ST_D_J and ST_D_T, from
// ST_D_OUT, held while the output is full; a marker result is registered at the edge of
// its own transfer; a rekey closes the input for the whole key schedule. a byte waits
// for the last result: three dependent reads share the single registered read port.
// reset: permutation identity through per-entry valid flops cleared at once, indices 0,
// key_length 16, key words 0; no clearing pass. depends on rc4_pkg, rc4_ctrl, rc4_dp
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_in
    input  logic [1:0]           s_axis_tuser,   // [1:0] op
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] data_out
    output logic [0:0]           m_axis_tuser,   // [0] is_marker
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [LEN_W-1:0]                 key_len_reg;
    logic [KEY_WORDS-1:0][WORD_W-1:0] key_word_reg;
    logic [LEN_W-1:0]                 key_len_eff;
    logic [KPOS_W-1:0]                key_last;
    logic [KEY_BYTES-1:0][7:0]        key_bytes;
    logic                             marker;

    cmd_t cmd;
    sts_t sts;

    // configuration registers, indexes past the last key word are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= LEN_W'(16);
            key_word_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_LENGTH: key_len_reg     <= cfg_data[LEN_W-1:0];
                REG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                REG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                REG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                REG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // length zero acts as one, lengths above the key storage saturate
    always_comb
    begin
        priority if (key_len_reg == '0)
        begin
            key_len_eff = LEN_W'(1);
        end
        else if (key_len_reg > LEN_W'(KEY_BYTES))
        begin
            key_len_eff = LEN_W'(KEY_BYTES);
        end
        else
        begin
            key_len_eff = key_len_reg;
        end
    end

    assign key_last  = KPOS_W'(key_len_eff - LEN_W'(1));
    // byte 0 of key word 0 sits in the low bits
    assign key_bytes = key_word_reg;

    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rc4_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (s_axis_tdata),
        .key_bytes  (key_bytes),
        .key_last   (key_last),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .out_marker (marker)
    );

    assign m_axis_tuser = marker;

endmodule

### hdl/rc4_ctrl.sv
// controller state machine of the rc4 stream cipher
// sequences key schedule and data byte steps; depends on rc4_pkg
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_K_RDN = 8'b0000_0010,
        ST_K_RDJ = 8'b0000_0100,
        ST_K_W1  = 8'b0000_1000,
        ST_K_W2  = 8'b0001_0000,
        ST_D_J   = 8'b0010_0000,
        ST_D_T   = 8'b0100_0000,
        ST_D_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_REKEY:
                        begin
                            cmd.perm_clr = 1'b1;
                            cmd.idx_clr  = 1'b1;
                            cmd.key_clr  = 1'b1;
                            state_next   = ST_K_RDN;
                        end
                        OP_DATA:
                        begin
                            cmd.rd_sel   = RD_INC_I;
                            cmd.i_inc    = 1'b1;
                            cmd.din_load = 1'b1;
                            state_next   = ST_D_J;
                        end
                        OP_MARKER:
                        begin
                            cmd.out_marker = 1'b1;
                        end
                        default:
                        begin
                            // unused op code: taken and dropped
                        end
                    endcase
                end
            end
            ST_K_RDN:
            begin
                cmd.rd_sel = RD_I;
                state_next = ST_K_RDJ;
            end
            ST_K_RDJ:
            begin
                cmd.rd_sel  = RD_J_KEY;
                cmd.j_load  = 1'b1;
                cmd.si_save = 1'b1;
                cmd.key_adv = 1'b1;
                state_next  = ST_K_W1;
            end
            ST_K_W1:
            begin
                cmd.wr_sel = WR_I_RD;
                state_next = ST_K_W2;
            end
            ST_K_W2:
            begin
                cmd.wr_sel = WR_J_SI;
                if (sts.last_n)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_K_RDN;
                end
            end
            ST_D_J:
            begin
                cmd.rd_sel  = RD_J_DATA;
                cmd.j_load  = 1'b1;
                cmd.si_save = 1'b1;
                state_next  = ST_D_T;
            end
            ST_D_T:
            begin
                cmd.rd_sel  = RD_T;
                cmd.t_save  = 1'b1;
                cmd.sj_save = 1'b1;
                cmd.wr_sel  = WR_I_RD;
                state_next  = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                // repeated write while stalled stores the same value again
                cmd.wr_sel = WR_J_SI;
                if (sts.out_free)
                begin
                    cmd.out_data = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_D_OUT && !sts.out_free) |=> (state_reg == ST_D_OUT))
        else $error("result step left while output slot full");

    a_ksa_loops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_W2 && !sts.last_n) |=> (state_reg == ST_K_RDN))
        else $error("key schedule left before last entry");

endmodule

### hdl/rc4_dp.sv
// datapath of the rc4 stream cipher: permutation memory, indices, output register
// driven by commands from rc4_ctrl; depends on rc4_pkg
module rc4_dp
    import rc4_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic [7:0]                in_data,
    input  logic [KEY_BYTES-1:0][7:0] key_bytes,
    input  logic [KPOS_W-1:0]         key_last,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [7:0]                out_data,
    output logic                      out_marker
);

    logic [7:0]           perm_mem [PERM_SIZE];
    logic [PERM_SIZE-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 rd_valid_reg;
    logic [7:0]           rd_addr_reg;

    logic [7:0]        i_reg;
    logic [7:0]        j_reg;
    logic [7:0]        si_reg;
    logic [7:0]        sj_reg;
    logic [7:0]        t_reg;
    logic [7:0]        din_reg;
    logic [KPOS_W-1:0] kpos_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_marker_reg;

    logic [7:0] rd_val;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] ks;

    // entry never written since identity reset reads as its own index
    assign rd_val = rd_valid_reg ? mem_q_reg : rd_addr_reg;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_INC_I:  rd_addr = i_reg + 8'd1;
            RD_I:      rd_addr = i_reg;
            RD_J_DATA: rd_addr = j_reg + rd_val;
            RD_J_KEY:  rd_addr = j_reg + rd_val + key_bytes[kpos_reg];
            RD_T:      rd_addr = si_reg + rd_val;
            default:   rd_addr = i_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_reg;
        wr_data = rd_val;
        unique case (cmd.wr_sel)
            WR_NONE: ;
            WR_I_RD:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = rd_val;
            end
            WR_J_SI:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = si_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            perm_mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= perm_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.perm_clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // keystream byte after the swap: swapped entries are forwarded
    always_comb
    begin
        priority if (t_reg == j_reg)
        begin
            ks = si_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = rd_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            kpos_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else
            begin
                if (cmd.i_inc)
                begin
                    i_reg <= i_reg + 8'd1;
                end
                if (cmd.j_load)
                begin
                    j_reg <= rd_addr;
                end
            end
            if (cmd.key_clr)
            begin
                kpos_reg <= '0;
            end
            else if (cmd.key_adv)
            begin
                kpos_reg <= (kpos_reg == key_last) ? '0 : kpos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.si_save)
        begin
            si_reg <= rd_val;
        end
        if (cmd.sj_save)
        begin
            sj_reg <= rd_val;
        end
        if (cmd.t_save)
        begin
            t_reg <= rd_addr;
        end
        if (cmd.din_load)
        begin
            din_reg <= in_data;
        end
        if (cmd.out_data)
        begin
            out_data_reg   <= din_reg ^ ks;
            out_marker_reg <= 1'b0;
        end
        else if (cmd.out_marker)
        begin
            out_data_reg   <= '0;
            out_marker_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_data || cmd.out_marker)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.last_n   = (i_reg == 8'(PERM_SIZE - 1));

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_marker = out_marker_reg;

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_data || cmd.out_marker) |-> sts.out_free)
        else $error("output register overwritten");

    a_clr_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.perm_clr |-> !wr_en)
        else $error("permutation write during identity reset");

    a_idx_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_clr |=> (i_reg == 8'd0 && j_reg == 8'd0))
        else $error("indices not cleared");

endmodule

### test/rc4_checker.sv
// checker for the rc4 stream cipher: follows register writes and input transfers,
// keeps its own cipher state, predicts each result and compares it field by field
// depends on rc4_pkg
module rc4_checker
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_in
    input  logic [1:0]           s_axis_tuser,   // [1:0] op
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,   // [7:0] data_out
    input  logic [0:0]           m_axis_tuser,   // [0] is_marker
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   outstanding,
    output int                   mismatches
);

    localparam int KEY_LEN_RESET = 16;

    typedef struct packed {
        logic [7:0] data_out;
        logic       is_marker;
    } cipher_out_t;

    logic [7:0]        sbox [PERM_SIZE];
    logic [7:0]        idx_i;
    logic [7:0]        idx_j;
    logic [LEN_W-1:0]  key_len;
    logic [WORD_W-1:0] key_word [KEY_WORDS];
    cipher_out_t       cipher_out_q [$];

    function automatic void set_identity();
        for (int n = 0; n < PERM_SIZE; n++)
            sbox[n] = 8'(n);
    endfunction

    function automatic void sbox_swap(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] tmp;
        tmp     = sbox[a];
        sbox[a] = sbox[b];
        sbox[b] = tmp;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t checker: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned len;
        int unsigned pos;
        logic [7:0]  jj;
        logic [7:0]  t;
        cipher_out_t want;
        if (!rst_n)
        begin
            set_identity();
            idx_i   = '0;
            idx_j   = '0;
            key_len = LEN_W'(KEY_LEN_RESET);
            foreach (key_word[w])
                key_word[w] = '0;
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_LENGTH:
                        key_len = cfg_data[LEN_W-1:0];
                    REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                        key_word[int'(cfg_index) - int'(REG_KEY_WORD_0)] = cfg_data;
                    default:
                        ;
                endcase
            end

            // result side first: a result never belongs to an input of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_out_q.size() == 0)
                    report_mismatch("result with nothing pending", m_axis_tdata, 8'h00);
                else
                begin
                    want = cipher_out_q.pop_front();
                    if (m_axis_tdata !== want.data_out)
                        report_mismatch("data_out", m_axis_tdata, want.data_out);
                    if (m_axis_tuser[0] !== want.is_marker)
                        report_mismatch("is_marker", 8'(m_axis_tuser), 8'(want.is_marker));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    OP_REKEY:
                    begin
                        // zero length acts as one, lengths past the key store saturate
                        len = (key_len == 0) ? 1 :
                              ((key_len > KEY_BYTES) ? KEY_BYTES : key_len);
                        set_identity();
                        jj = '0;
                        for (int n = 0; n < PERM_SIZE; n++)
                        begin
                            pos = n % len;
                            jj  = jj + sbox[n] + key_word[pos / 8][(pos % 8) * 8 +: 8];
                            sbox_swap(8'(n), jj);
                        end
                        idx_i = '0;
                        idx_j = '0;
                    end
                    OP_DATA:
                    begin
                        idx_i = idx_i + 8'd1;
                        idx_j = idx_j + sbox[idx_i];
                        sbox_swap(idx_i, idx_j);
                        t = sbox[idx_i] + sbox[idx_j];
                        cipher_out_q.push_back('{data_out: s_axis_tdata ^ sbox[t],
                                                 is_marker: 1'b0});
                    end
                    OP_MARKER:
                        cipher_out_q.push_back('{data_out: 8'h00, is_marker: 1'b1});
                    default:
                        ;
                endcase
            end
            outstanding <= cipher_out_q.size();
        end
    end

endmodule

### test/tb_top.sv
// testbench top of the rc4 stream cipher: clock, reset, stimulus, idling and verdict
// prediction and comparison live in rc4_checker; depends on rc4_pkg and the rtl
module tb_top;
    import rc4_pkg::*;

    localparam int CLK_HALF        = 5;
    // a rekey keeps the input closed for the whole key schedule
    localparam int REKEY_CYCLES    = 1 + PERM_SIZE * 4;
    localparam int SETTLE_CYCLES   = REKEY_CYCLES + 32;
    // cycles with no transfer on either stream before the run is given up
    localparam int WATCHDOG_LIMIT  = 6000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_ROUNDS   = 8;
    localparam int ITEMS_PER_ROUND = 200;
    // the one op encoding with no meaning, the block must drop it
    localparam logic [1:0] OP_UNUSED = 2'(OP_MARKER) + 2'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] data_in
    logic [1:0]           s_axis_tuser;   // [1:0] op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] data_out
    logic [0:0]           m_axis_tuser;   // [0] is_marker
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int                   results_pending;
    int                   mismatch_total;
    int                   send_idle_pct;
    int                   stall_pct;
    logic                 hold_req;

    rc4_stream_cipher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rc4_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .outstanding   (results_pending),
        .mismatches    (mismatch_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off counted here whenever
    // the stimulus flips hold_req
    initial
    begin : receiver
        logic hold_seen;
        int   hold_left;
        hold_seen     = 1'b0;
        hold_left     = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req !== hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // give up when neither stream moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // one input transfer, after a random idle gap; tvalid stays high afterwards
    // so back-to-back items never lower and raise it in the same step
    task automatic send_item(input logic [1:0] op, input logic [7:0] din);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= din;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop offering and wait until every predicted result has been seen
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // idle point for register writes: also covers a rekey or dropped item still in flight
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // key length, all four key words, and a write to an unused index that must do nothing
    task automatic load_key(input logic [LEN_W-1:0] len,
                            input logic [KEY_WORDS*WORD_W-1:0] key);
        write_reg(REG_KEY_LENGTH, WORD_W'(len));
        for (int w = 0; w < KEY_WORDS; w++)
            write_reg(CFG_IDX_W'(int'(REG_KEY_WORD_0) + w), key[w*WORD_W +: WORD_W]);
        write_reg(CFG_IDX_W'(int'(REG_KEY_WORD_3) + $urandom_range(1, 3)),
                  {$urandom, $urandom});
    endtask

    // mostly cipher bytes, some markers, a few dropped ops and mid-stream rekeys
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 88)
            send_item(OP_DATA, 8'($urandom));
        else if (pick < 94)
            send_item(OP_MARKER, 8'($urandom));
        else if (pick < 97)
            send_item(OP_UNUSED, 8'($urandom));
        else
            send_item(OP_REKEY, 8'($urandom));
    endtask

    function automatic logic [KEY_WORDS*WORD_W-1:0] random_key();
        logic [KEY_WORDS*WORD_W-1:0] key;
        for (int w = 0; w < KEY_WORDS * WORD_W / 32; w++)
            key[w*32 +: 32] = $urandom;
        return key;
    endfunction

    initial
    begin : stimulus
        logic [LEN_W-1:0] len;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_DATA;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_KEY_LENGTH;
        cfg_data      <= '0;
        hold_req      <= 1'b0;
        stall_pct     <= 0;
        send_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight out of reset: identity permutation, no rekey yet
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hff);
        send_item(OP_MARKER, 8'ha5);
        send_item(OP_UNUSED, 8'h5a);
        send_item(OP_DATA, 8'h80);
        // rekey with the reset key: 16 zero bytes
        send_item(OP_REKEY, 8'h00);
        send_item(OP_DATA, 8'h01);
        send_item(OP_MARKER, 8'hff);

        // zero key length behaves as a single byte
        settle();
        load_key('0, '1);
        send_item(OP_REKEY, 8'hff);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hff);
        send_item(OP_MARKER, 8'h00);

        // full 32 byte key
        settle();
        load_key(LEN_W'(KEY_BYTES), random_key());
        send_item(OP_REKEY, 8'h00);
        send_item(OP_DATA, 8'h55);
        send_item(OP_DATA, 8'haa);

        // largest length value saturates to the key store size
        settle();
        load_key('1, random_key());
        send_item(OP_REKEY, 8'h00);
        send_item(OP_DATA, 8'h3c);
        send_item(OP_UNUSED, 8'hff);
        send_item(OP_DATA, 8'hc3);

        // one byte key of zero
        settle();
        load_key(LEN_W'(1), '0);
        send_item(OP_REKEY, 8'h00);
        send_item(OP_DATA, 8'h7f);

        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            settle();
            case (round % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     <= 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct     <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     <= 86;
                end
                default:
                begin
                    send_idle_pct = 29;
                    stall_pct     <= 29;
                end
            endcase
            // extremes of the length now and then, otherwise any 6 bit value
            case ($urandom_range(7))
                0:       len = '0;
                1:       len = LEN_W'(1);
                2:       len = LEN_W'(KEY_BYTES);
                3:       len = '1;
                default: len = LEN_W'($urandom);
            endcase
            load_key(len, random_key());
            send_item(OP_REKEY, 8'($urandom));
            for (int k = 0; k < ITEMS_PER_ROUND; k++)
            begin
                // back-pressure: receiver holds off while the sender keeps offering
                if (round == 0 && k == 20)
                    hold_req <= ~hold_req;
                // sender pause until all results are back, mid-round
                if (k == ITEMS_PER_ROUND / 2)
                    drain();
                send_random_item();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
